/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ucpb_pkg.sv */
// ---------------------------------------------------------------------------
// ucpb_pkg
// Types, sizes and helpers for the colour palette builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucpb_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COLOUR_W    = 32;
  localparam int INDEX_W     = 11;
  localparam int TOTAL_W     = 12;

  localparam logic [7:0] OPAQUE_ALPHA = 8'd255;
  localparam int USE_RED   = 0;
  localparam int USE_GREEN = 1;
  localparam int USE_BLUE  = 2;
  localparam int USE_ALPHA = 3;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [INDEX_W-1:0] colour_index;
    logic               is_new_colour;
    logic [TOTAL_W-1:0] colour_total;
    logic               table_overflow;
    logic [3:0]         channel_use;
    logic               image_done;
  } result_t;

  typedef struct packed {
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [COLOUR_W-1:0] wr_data;
  } ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // colour word: red in bits 7:0, green 15:8, blue 23:16, alpha 31:24
  function automatic logic [3:0] flags_of(input logic [COLOUR_W-1:0] c);
    logic [3:0] f;
    f            = 4'b0000;
    f[USE_RED]   = (c[7:0] != 8'd0);
    f[USE_GREEN] = (c[15:8] != 8'd0);
    f[USE_BLUE]  = (c[23:16] != 8'd0);
    f[USE_ALPHA] = (c[31:24] != OPAQUE_ALPHA);
    return f;
  endfunction

endpackage

/* rtl/ucpb_if.sv */
// ---------------------------------------------------------------------------
// ucpb_if
// Valid/ready channels for pixels, results and the mode register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ucpb_pixel_if;
  logic            valid;
  logic            ready;
  ucpb_pkg::pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface ucpb_result_if;
  logic             valid;
  logic             ready;
  ucpb_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface ucpb_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

/* rtl/unique_colour_palette_builder.sv */
// Search: a colour not yet stored is compared with all N stored colours (N = colours
//   stored) before it is appended; a match ends the scan early; an empty table skips it.
// Flow: one pixel at a time, set by the one-read-per-cycle table scan; the next
//   request is taken while a result waits.
// Reset: synchronous active-low rst_n clears count, flags, overflow and handshakes,
//   has_alpha returns to 1; the table RAM is not cleared, no sweep is needed.
// ---------------------------------------------------------------------------
// unique_colour_palette_builder
// Builds a palette of distinct pixel colours with per-pixel index reports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module unique_colour_palette_builder (
  input  logic          clk,
  input  logic          rst_n,
  ucpb_pixel_if.sink    in_ch,
  ucpb_result_if.source out_ch,
  ucpb_cfg_if.sink      cfg_ch
);

  logic                          has_alpha_r;
  ucpb_pkg::ram_req_t            ram_req;
  logic [ucpb_pkg::COLOUR_W-1:0] rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_alpha_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      has_alpha_r <= cfg_ch.data;
    end
  end

  ucpb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .has_alpha (has_alpha_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .ram_req   (ram_req),
    .rd_data   (rd_data)
  );

  ucpb_table_ram #(
    .WIDTH (ucpb_pkg::COLOUR_W),
    .DEPTH (ucpb_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* rtl/ucpb_table_ram.sv */
// ---------------------------------------------------------------------------
// ucpb_table_ram
// Simple dual-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucpb_table_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ucpb_engine.sv */
// ---------------------------------------------------------------------------
// ucpb_engine
// Search sequencer: scans the table, appends new colours while room remains, builds results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucpb_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              has_alpha,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ucpb_pkg::pixel_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ucpb_pkg::result_t                 out_data,
  output ucpb_pkg::ram_req_t                ram_req,
  input  logic [ucpb_pkg::COLOUR_W-1:0]     rd_data
);

  ucpb_pkg::state_t state_r, state_nxt;

  logic [ucpb_pkg::COLOUR_W-1:0] colour_r, colour_nxt;
  logic                          last_r, last_nxt;
  logic [ucpb_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic                          found_r, found_nxt;
  logic [ucpb_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [3:0]                    flags_r, flags_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ucpb_pkg::result_t             out_data_r, out_data_nxt;

  logic [ucpb_pkg::COLOUR_W-1:0] colour_in;
  logic [7:0]                    alpha_in;
  logic                          out_free;
  logic [ucpb_pkg::ADDR_W-1:0]   res_idx;
  logic                          res_new;

  assign alpha_in  = has_alpha ? in_data.pixel_alpha : ucpb_pkg::OPAQUE_ALPHA;
  assign colour_in = {alpha_in, in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red};
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ucpb_pkg::ST_IDLE;
      count_r     <= '0;
      flags_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    colour_r   <= colour_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    colour_nxt    = colour_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_req       = '0;
    res_idx       = '0;
    res_new       = 1'b0;
    in_ready      = 1'b0;

    unique case (state_r)
      ucpb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          colour_nxt = colour_in;
          last_nxt   = in_data.last_pixel;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          if (count_r == '0) begin
            state_nxt = ucpb_pkg::ST_FINISH;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = '0;
            state_nxt       = ucpb_pkg::ST_SCAN;
          end
        end
      end
      ucpb_pkg::ST_SCAN: begin
        if (rd_data == colour_r) begin
          found_nxt = 1'b1;
          state_nxt = ucpb_pkg::ST_FINISH;
        end else if (ucpb_pkg::CNT_W'(idx_r) + ucpb_pkg::CNT_W'(1) == count_r) begin
          state_nxt = ucpb_pkg::ST_FINISH;
        end else begin
          idx_nxt         = idx_r + ucpb_pkg::ADDR_W'(1);
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_r + ucpb_pkg::ADDR_W'(1);
        end
      end
      ucpb_pkg::ST_FINISH: begin
        if (out_free) begin
          if (found_r) begin
            res_idx = idx_r;
          end else if (count_r < ucpb_pkg::CNT_W'(ucpb_pkg::TABLE_DEPTH)) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = count_r[ucpb_pkg::ADDR_W-1:0];
            ram_req.wr_data = colour_r;
            res_idx         = count_r[ucpb_pkg::ADDR_W-1:0];
            res_new         = 1'b1;
            count_nxt       = count_r + ucpb_pkg::CNT_W'(1);
            flags_nxt       = flags_r | ucpb_pkg::flags_of(colour_r);
          end else begin
            ovf_nxt = 1'b1;
          end
          out_data_nxt.colour_index   = ucpb_pkg::INDEX_W'(res_idx);
          out_data_nxt.is_new_colour  = res_new;
          out_data_nxt.colour_total   = ucpb_pkg::TOTAL_W'(count_nxt);
          out_data_nxt.table_overflow = ovf_nxt;
          out_data_nxt.channel_use    = flags_nxt;
          out_data_nxt.image_done     = last_r;
          out_valid_nxt               = 1'b1;
          if (last_r) begin
            count_nxt = '0;
            flags_nxt = '0;
            ovf_nxt   = 1'b0;
          end
          state_nxt = ucpb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ucpb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ucpb_checker.sv */
// ---------------------------------------------------------------------------
// ucpb_checker
// Port-level checks on palette results and handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucpb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ucpb_pkg::result_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  logic new_hit;
  logic in_take;
  logic cfg_take;
  logic tail_ok;
  logic total_ok;

  assign new_hit  = out_valid && out_data.is_new_colour;
  assign in_take  = in_valid && in_ready;
  assign cfg_take = cfg_valid && cfg_ready;
  assign tail_ok  = (ucpb_pkg::TOTAL_W'(out_data.colour_index) + ucpb_pkg::TOTAL_W'(1))
                    == out_data.colour_total;
  assign total_ok = (out_data.colour_total != '0) &&
                    (out_data.colour_total <= ucpb_pkg::TOTAL_W'(ucpb_pkg::TABLE_DEPTH));

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLY(a_new_is_tail, clk, rst_n, new_hit, tail_ok)
  `ASSERT_IMPLY(a_new_no_ovf, clk, rst_n, new_hit, !out_data.table_overflow)
  `ASSERT_IMPLY(a_total_range, clk, rst_n, out_valid, total_ok)
  `ASSERT_NEXT(a_take_stalls, clk, rst_n, in_take && !cfg_take, !in_ready)

endmodule

bind unique_colour_palette_builder ucpb_checker u_ucpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);
